@@ sv/vrt_pkg.sv @@
package vrt_pkg;

  localparam int GRID_SIZE = 32;
  localparam int CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int ADDR_W = $clog2(CELLS);

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  localparam logic [1:0] REG_BASE_X = 2'd0;
  localparam logic [1:0] REG_BASE_Y = 2'd1;
  localparam logic [1:0] REG_BASE_Z = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [14:0]        voxel_index;
    logic               voxel_solid;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [9:0]         step_limit;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [15:0] hit_x;
    logic signed [15:0] hit_y;
    logic signed [15:0] hit_z;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    logic signed [15:0] prev_z;
  } rsp_t;

endpackage

@@ sv/vrt_ram.sv @@
module vrt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/vrt_div.sv @@
module vrt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [30:0] quotient
);
  // restoring division of 2^30 by divisor, one quotient bit a cycle

  logic        busy;
  logic [4:0]  cnt;
  logic [15:0] rem;
  logic [15:0] dvs;
  logic [16:0] trial;
  logic        ge;

  always_comb begin
    trial = {rem, (cnt == 5'd0)};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= '0;
      end else if (busy) begin
        if (ge) begin
          rem <= 16'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[15:0];
        end
        quotient <= {quotient[29:0], ge};
        cnt      <= cnt + 5'd1;
        if (cnt == 5'd30) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/voxel_ray_traversal.sv @@
// Voxel ray traversal (3D DDA) over a cube of solid/empty bits.
// Request channel req/req_valid/req_stall: a transaction with cmd write
// sets one bit of the store and gives no response; cmd cast traces a ray
// and gives exactly one response on rsp/rsp_valid/rsp_stall.
// Window corner registers are written through cfg_wr_en/cfg_index/cfg_data;
// the user writes them only while idle, which the block itself does not enforce.
// A write is taken in the idle state. A cast is accepted, then each axis runs
// a set-up of divider start, 31 serial divide steps, a hand-over of the
// quotient, one multiply and one side distance load (a zero direction
// component skips all of it in its single set-up state); each cell step runs
// the STEP, LOOK and TEST states, the step loop waiting on the registered read
// of the bit store, and the FIN state loads the response.
// Only one request is worked on at a time; req_stall is high while busy.
// After reset the store is cleared one entry a cycle, all CELLS entries (32768
// for a 32 cube), with req_stall high; configuration writes still land.
// A finished response sits in an output register; while rsp_stall holds it
// the next cast may run, but it waits at the end until the register frees.
module voxel_ray_traversal (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              req_valid,
  output logic              req_stall,
  input  vrt_pkg::req_t     req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output vrt_pkg::rsp_t     rsp
);
  import vrt_pkg::*;

  localparam logic [3:0] ST_CLEAR = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DIVS  = 4'd2;
  localparam logic [3:0] ST_DIVW  = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_SIDE  = 4'd5;
  localparam logic [3:0] ST_STEP  = 4'd6;
  localparam logic [3:0] ST_LOOK  = 4'd7;
  localparam logic [3:0] ST_TEST  = 4'd8;
  localparam logic [3:0] ST_FIN   = 4'd9;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  logic [3:0]        state;
  logic [ADDR_W-1:0] clr;
  logic [15:0]       base [3];
  logic [15:0]       cur [3];
  logic [15:0]       prev [3];
  logic [15:0]       frac [3];
  logic [15:0]       mag [3];
  logic [2:0]        dneg;
  logic [2:0]        dzero;
  logic [31:0]       side [3];
  logic [31:0]       delta [3];
  logic [9:0]        steps;
  logic [1:0]        ax;
  logic [48:0]       prod;
  logic              inwin_q;
  logic              hit_flag;

  logic              div_start;
  logic              div_done;
  logic [30:0]       div_q;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic              ram_rdata;

  logic              take;
  logic              rsp_load;
  logic [31:0]       widx;
  logic [1:0]        sel;
  logic [32:0]       sum;
  logic [31:0]       side_new;
  logic [15:0]       cell_new;
  logic [16:0]       part;
  logic [16:0]       loc [3];
  logic              inwin;
  logic [31:0]       addr_full;

  assign req_stall = (state != ST_IDLE);
  assign take      = req_valid && !req_stall;
  assign rsp_load  = (state == ST_FIN) && (!rsp_valid || !rsp_stall);
  assign widx      = {17'd0, req.voxel_index};
  assign div_start = (state == ST_DIVS) && (mag[ax] != 16'd0);

  vrt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .divisor  (mag[ax]),
    .done     (div_done),
    .quotient (div_q)
  );

  vrt_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // store write port: clearing sweep or write command
  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = take && (req.cmd == CMD_WRITE) && (widx < 32'(CELLS));
      ram_waddr = widx[ADDR_W-1:0];
      ram_wdata = req.voxel_solid;
    end
  end

  // axis choice, ties to z then y
  always_comb begin
    if (side[AX_X] < side[AX_Y]) begin
      sel = (side[AX_X] < side[AX_Z]) ? AX_X : AX_Z;
    end else begin
      sel = (side[AX_Y] < side[AX_Z]) ? AX_Y : AX_Z;
    end
    sum      = {1'b0, side[sel]} + {1'b0, delta[sel]};
    side_new = sum[32] ? SAT32 : sum[31:0];
    if (dzero[sel]) begin
      cell_new = cur[sel];
    end else if (dneg[sel]) begin
      cell_new = cur[sel] - 16'd1;
    end else begin
      cell_new = cur[sel] + 16'd1;
    end
    part = dneg[ax] ? {1'b0, frac[ax]} : (17'h10000 - {1'b0, frac[ax]});
  end

  // window test and store address of the current cell
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      loc[a] = {cur[a][15], cur[a]} - {base[a][15], base[a]};
    end
    inwin = 1'b1;
    for (int a = 0; a < 3; a++) begin
      if (loc[a][16] || (loc[a][15:0] >= 16'(GRID_SIZE))) begin
        inwin = 1'b0;
      end
    end
    addr_full = 32'(loc[AX_Z][15:0]) * 32'(GRID_SIZE * GRID_SIZE)
              + 32'(loc[AX_Y][15:0]) * 32'(GRID_SIZE)
              + 32'(loc[AX_X][15:0]);
    ram_raddr = addr_full[ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      base[0]   <= '0;
      base[1]   <= '0;
      base[2]   <= '0;
      rsp_valid <= 1'b0;
      steps     <= '0;
      ax        <= AX_X;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_BASE_X: base[0] <= cfg_data;
          REG_BASE_Y: base[1] <= cfg_data;
          REG_BASE_Z: base[2] <= cfg_data;
          default: ;
        endcase
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr <= clr + ADDR_W'(1);
          if (clr == ADDR_W'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (take && (req.cmd == CMD_CAST)) begin
            cur[0]   <= req.origin_x[31:16];
            cur[1]   <= req.origin_y[31:16];
            cur[2]   <= req.origin_z[31:16];
            prev[0]  <= req.origin_x[31:16];
            prev[1]  <= req.origin_y[31:16];
            prev[2]  <= req.origin_z[31:16];
            frac[0]  <= req.origin_x[15:0];
            frac[1]  <= req.origin_y[15:0];
            frac[2]  <= req.origin_z[15:0];
            mag[0]   <= req.dir_x[15] ? 16'(-req.dir_x) : req.dir_x;
            mag[1]   <= req.dir_y[15] ? 16'(-req.dir_y) : req.dir_y;
            mag[2]   <= req.dir_z[15] ? 16'(-req.dir_z) : req.dir_z;
            dneg     <= {req.dir_z[15], req.dir_y[15], req.dir_x[15]};
            dzero    <= {req.dir_z == 16'd0, req.dir_y == 16'd0, req.dir_x == 16'd0};
            steps    <= req.step_limit;
            hit_flag <= 1'b0;
            ax       <= AX_X;
            state    <= ST_DIVS;
          end
        end
        ST_DIVS: begin
          if (mag[ax] == 16'd0) begin
            delta[ax] <= SAT32;
            side[ax]  <= SAT32;
            if (ax == AX_Z) begin
              state <= (steps == 10'd0) ? ST_FIN : ST_STEP;
            end else begin
              ax <= ax + 2'd1;
            end
          end else begin
            state <= ST_DIVW;
          end
        end
        ST_DIVW: begin
          if (div_done) begin
            delta[ax] <= {1'b0, div_q};
            state     <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= 49'(part) * 49'(delta[ax]);
          state <= ST_SIDE;
        end
        ST_SIDE: begin
          side[ax] <= prod[48] ? SAT32 : prod[47:16];
          if (ax == AX_Z) begin
            state <= (steps == 10'd0) ? ST_FIN : ST_STEP;
          end else begin
            ax    <= ax + 2'd1;
            state <= ST_DIVS;
          end
        end
        ST_STEP: begin
          steps     <= steps - 10'd1;
          prev[0]   <= cur[0];
          prev[1]   <= cur[1];
          prev[2]   <= cur[2];
          side[sel] <= side_new;
          cur[sel]  <= cell_new;
          state     <= ST_LOOK;
        end
        ST_LOOK: begin
          inwin_q <= inwin;
          state   <= ST_TEST;
        end
        ST_TEST: begin
          if (inwin_q && ram_rdata) begin
            hit_flag <= 1'b1;
            state    <= ST_FIN;
          end else if (steps == 10'd0) begin
            state <= ST_FIN;
          end else begin
            state <= ST_STEP;
          end
        end
        ST_FIN: begin
          // response register must be free before the result lands
          if (rsp_load) begin
            rsp.hit     <= hit_flag;
            rsp.hit_x   <= cur[0];
            rsp.hit_y   <= cur[1];
            rsp.hit_z   <= cur[2];
            rsp.prev_x  <= prev[0];
            rsp.prev_y  <= prev[1];
            rsp.prev_z  <= prev[2];
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> req_stall)
    else $error("request taken during clearing sweep");

  a_step_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |=> (steps == $past(steps) - 10'd1))
    else $error("step counter did not decrement");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVW))
    else $error("divider finished outside its wait state");

  a_hit_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TEST) && hit_flag |-> 1'b0)
    else $error("step loop running after a hit");
`endif

endmodule

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vrt_pkg::*;

  localparam int GS = GRID_SIZE;
  localparam longint CYCLE_LIMIT = 4_000_000;
  // index with no register behind it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  voxel_ray_traversal DUT (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always #5 clk = ~clk;

  typedef struct {
    req_t r;
    bit chk;
    rsp_t want;
  } row_t;

  // predictor state
  bit solid_map [CELLS];
  logic signed [15:0] corner [3];
  rsp_t pending_hits [$];
  row_t rows [$];
  int mismatches = 0;
  longint cycles = 0;
  bit hold_off = 0;
  bit stim_done = 0;
  int stall_run = 0;

  function automatic void add_row(req_t r, bit chk, rsp_t want);
    row_t w;
    w.r = r; w.chk = chk; w.want = want;
    rows.insert(rows.size(), w);
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT32 : s[31:0];
  endfunction

  function automatic bit cell_solid(logic signed [15:0] c [3]);
    int unsigned idx;
    int l;
    idx = 0;
    for (int a = 2; a >= 0; a--) begin
      l = int'(c[a]) - int'(corner[a]);
      if (l < 0 || l >= GS) return 0;
      idx = idx * GS + l;
    end
    return solid_map[idx];
  endfunction

  function automatic rsp_t trace_ray(req_t r);
    logic signed [31:0] org [3];
    logic signed [15:0] dir [3];
    logic signed [15:0] cur [3];
    logic signed [15:0] prv [3];
    logic [31:0] side [3];
    logic [31:0] dlt [3];
    int stp [3];
    logic [63:0] part;
    int mag, ax, n;
    bit found;
    rsp_t o;
    org[0] = r.origin_x; org[1] = r.origin_y; org[2] = r.origin_z;
    dir[0] = r.dir_x; dir[1] = r.dir_y; dir[2] = r.dir_z;
    for (int a = 0; a < 3; a++) begin
      cur[a] = org[a][31:16];
      mag = dir[a] < 0 ? -int'(dir[a]) : int'(dir[a]);
      if (mag == 0) begin
        dlt[a] = SAT32; side[a] = SAT32; stp[a] = 0;
      end else begin
        dlt[a] = 32'((64'd1 << 30) / mag);
        part = dir[a] > 0 ? 64'd65536 - 64'(org[a][15:0]) : 64'(org[a][15:0]);
        part = (part * 64'(dlt[a])) >> 16;
        side[a] = part > 64'(SAT32) ? SAT32 : part[31:0];
        stp[a] = dir[a] > 0 ? 1 : -1;
      end
      prv[a] = cur[a];
    end
    found = 0;
    n = int'(r.step_limit);
    while (n > 0 && !found) begin
      n--;
      prv = cur;
      if (side[0] < side[1]) ax = side[0] < side[2] ? 0 : 2;
      else ax = side[1] < side[2] ? 1 : 2;
      side[ax] = sat_sum(side[ax], dlt[ax]);
      cur[ax] = 16'(cur[ax] + stp[ax]);
      found = cell_solid(cur);
    end
    o.hit = found;
    o.hit_x = cur[0]; o.hit_y = cur[1]; o.hit_z = cur[2];
    o.prev_x = prv[0]; o.prev_y = prv[1]; o.prev_z = prv[2];
    return o;
  endfunction

  // one write, then a wait with the enable low so that writes never run into each other
  task automatic apply_corner(logic [1:0] i, logic [15:0] v);
    cfg_wr_en <= 1'b1; cfg_index <= i; cfg_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (i <= REG_BASE_Z) corner[i] = v;
    @(posedge clk);
  endtask

  // keeps valid high across back-to-back transactions, but drops it for a random gap before some
  task automatic offer(req_t r, bit chk, rsp_t want);
    rsp_t got;
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
          : ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= r; req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (r.cmd == CMD_WRITE) begin
      if (r.voxel_index < CELLS) solid_map[r.voxel_index] = r.voxel_solid;
    end else begin
      got = trace_ray(r);
      if (chk && got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("table row mismatch: expected %p predicted %p", want, got);
      end
      pending_hits.insert(pending_hits.size(), got);
    end
  endtask

  task automatic drain();
    int t;
    req_valid <= 1'b0;
    t = 0;
    while (pending_hits.size() != 0 && t < 200000) begin
      @(posedge clk); t++;
    end
    repeat (400) @(posedge clk);
  endtask

  function automatic req_t cast_req(int ox, int oy, int oz, int dx, int dy, int dz, int lim);
    req_t r;
    r = '0;
    r.cmd = CMD_CAST;
    r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
    r.dir_x = 16'(dx); r.dir_y = 16'(dy); r.dir_z = 16'(dz);
    r.step_limit = 10'(lim);
    return r;
  endfunction

  function automatic req_t wr_req(int idx, bit s);
    req_t r;
    r = '0;
    r.cmd = CMD_WRITE; r.voxel_index = 15'(idx); r.voxel_solid = s;
    return r;
  endfunction

  function automatic req_t rand_cast(bit aimed);
    req_t r;
    r = '0;
    r.cmd = CMD_CAST;
    r.voxel_index = 15'($urandom); r.voxel_solid = 1'($urandom);
    if (aimed) begin
      r.origin_x = (int'(corner[0]) + $urandom_range(0, GS - 1)) * 65536 + $urandom_range(0, 65535);
      r.origin_y = (int'(corner[1]) + $urandom_range(0, GS - 1)) * 65536 + $urandom_range(0, 65535);
      r.origin_z = (int'(corner[2]) + $urandom_range(0, GS - 1)) * 65536 + $urandom_range(0, 65535);
      r.step_limit = 10'($urandom_range(0, 40));
    end else begin
      r.origin_x = $urandom; r.origin_y = $urandom; r.origin_z = $urandom;
      r.step_limit = ($urandom_range(0, 15) == 0) ? 10'($urandom_range(0, 1023))
                     : 10'($urandom_range(0, 20));
    end
    r.dir_x = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
    r.dir_y = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
    r.dir_z = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
    if ($urandom_range(0, 3) == 0) r.dir_x = $urandom_range(0, 1) ? 16'sh4000 : -16'sh4000;
    return r;
  endfunction

  // response checker
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected ray result %p", rsp);
      end else begin
        want = pending_hits.pop_front();
        if (rsp !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("ray result mismatch: expected %p got %p", want, rsp);
        end
      end
    end
  end

  // receiver stalls: mostly short, now and then a longer run, one long hold-off
  always @(posedge clk) begin
    if (hold_off) rsp_stall <= 1'b1;
    else if (stim_done) rsp_stall <= 1'b0;
    else if (stall_run > 0) begin
      rsp_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else if ($urandom_range(0, 49) == 0) begin
      rsp_stall <= 1'b1;
      stall_run <= $urandom_range(20, 80);
    end else rsp_stall <= ($urandom_range(0, 3) == 0);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rsp_t zero_lim;
    req_t r;
    int k;
    foreach (corner[a]) corner[a] = '0;
    foreach (solid_map[i]) solid_map[i] = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero step limit: start cell on both sides, no hit
    zero_lim = '{hit: 1'b0, hit_x: 16'sd3, hit_y: -16'sd1, hit_z: 16'sd0,
                 prev_x: 16'sd3, prev_y: -16'sd1, prev_z: 16'sd0};
    add_row(cast_req(32'h0003_8000, 32'hFFFF_0001, 0, 100, -5, 7, 0), 1, zero_lim);
    add_row(wr_req(1 + 0 * GS + 0, 1), 0, '0);
    add_row(wr_req(CELLS - 1, 1), 0, '0);
    add_row(wr_req(5 * GS * GS + 5 * GS + 9, 1), 0, '0);
    add_row(wr_req(0, 1), 0, '0);
    add_row(cast_req(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 16384, 0, 0, 10), 0, '0);
    add_row(cast_req(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 0, 0, 0, 5), 0, '0);
    add_row(cast_req(32'h0000_0000, 0, 0, 16384, 16384, 16384, 20), 0, '0);
    add_row(cast_req(32'h0005_0000, 32'h0005_8000, 32'h0005_8000, 16384, 0, 0, 10), 0, '0);
    add_row(cast_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32767, 32767, 32767, 1023),
            0, '0);
    add_row(cast_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -32768, -32768, -32768, 1023),
            0, '0);
    add_row(cast_req(32'h0020_8000, 32'h001F_8000, 32'h001F_8000, -16384, 0, 0, 4), 0, '0);
    add_row(cast_req(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 1, -1, 1, 3), 0, '0);
    add_row(wr_req(1, 0), 0, '0);
    add_row(cast_req(32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 16384, 0, 0, 2), 0, '0);
    foreach (rows[i]) offer(rows[i].r, rows[i].chk, rows[i].want);
    drain();

    // long receiver hold-off while casts keep coming
    hold_off = 1;
    fork
      begin repeat (3000) @(posedge clk); hold_off = 0; end
      for (k = 0; k < 6; k++) offer(rand_cast(1), 0, '0);
    join
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin apply_corner(REG_BASE_X, 16'h7FF0); apply_corner(REG_BASE_Y, 16'h8000);
                 apply_corner(REG_BASE_Z, 16'h7FFF); end
        1: begin apply_corner(REG_BASE_X, 16'h8000); apply_corner(REG_BASE_Y, 16'h7FFF);
                 apply_corner(REG_BASE_Z, 16'h8000); end
        2: begin apply_corner(REG_BASE_X, 16'($urandom)); apply_corner(REG_BASE_Y, -16'sd5);
                 apply_corner(REG_BASE_Z, 16'd12); apply_corner(REG_UNUSED, 16'h1234); end
        default: begin apply_corner(REG_BASE_X, 16'($urandom_range(0, 64) - 32));
                 apply_corner(REG_BASE_Y, 16'($urandom_range(0, 64) - 32));
                 apply_corner(REG_BASE_Z, 16'($urandom_range(0, 64) - 32)); end
      endcase
      for (k = 0; k < 365; k++) begin
        if ($urandom_range(0, 2) == 0) begin
          r = wr_req($urandom_range(0, CELLS - 1), $urandom_range(0, 3) != 0);
          r.origin_x = $urandom; r.dir_y = 16'($urandom); r.step_limit = 10'($urandom);
        end else
          r = rand_cast($urandom_range(0, 4) != 0);
        offer(r, 0, '0);
      end
      drain();
    end

    stim_done = 1;
    drain();
    if (mismatches == 0 && pending_hits.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/vrt_pkg.sv
sv/vrt_ram.sv
sv/vrt_div.sv
sv/voxel_ray_traversal.sv
tb/tb_top.sv
